[sv/ushp_pkg.sv]
// Package: phase encoding, protocol codes and character constants for the URL parser.
`default_nettype none
package ushp_pkg;

    typedef enum logic [2:0] {
        PH_SCHEME     = 3'd0,
        PH_SEP        = 3'd1,
        PH_HOST_FIRST = 3'd2,
        PH_HOST       = 3'd3,
        PH_PORT_FIRST = 3'd4,
        PH_PORT       = 3'd5,
        PH_DOC        = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        PROTO_HTTP  = 2'd0,
        PROTO_HTTPS = 2'd1,
        PROTO_FTP   = 2'd2
    } t_proto;

    typedef enum logic [2:0] {
        PART_SCHEME = 3'd0,
        PART_SEP    = 3'd1,
        PART_HOST   = 3'd2,
        PART_PORT   = 3'd3,
        PART_SLASH  = 3'd4,
        PART_DOC    = 3'd5
    } t_part;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_LO_S  = 8'h73;

    localparam logic [16:0] PORT_MAX = 17'd65535;
    localparam logic [16:0] PORT_SAT = 17'd65536;
    localparam logic [15:0] PORT_HTTP  = 16'd80;
    localparam logic [15:0] PORT_HTTPS = 16'd443;
    localparam logic [15:0] PORT_FTP   = 16'd21;

endpackage
`default_nettype wire

[sv/url_scheme_host_port_parser_top.sv]
// URL scheme/host/port parser: input register, per-byte parse logic, output register.
// Each byte passes through the input register and then the output register; a stall
// at the output can hold it in either one.
// Throughput: one byte per cycle; the input register and the output register
// each advance whenever the stage after them is empty or being drained.
// Reset (i_rst_n low, synchronous): both stages empty, parse state back to scheme start.
// State also returns to scheme start after each byte with tlast set.
`default_nettype none
module url_scheme_host_port_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  wire logic        s_axis_tlast,   // last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] ch_out, [8] valid_res,
                                             // [10:9] proto, [26:11] port_num, rest 0
    output logic [2:0]       m_axis_tuser,   // [2:0] part
    output logic             m_axis_tlast    // done_res
);
    import ushp_pkg::*;

    // input stage
    logic        r_in_valid;
    logic [7:0]  r_in_ch;
    logic        r_in_last;

    // parse state
    t_phase      r_phase, n_phase;
    logic [2:0]  r_pos, n_pos;
    t_proto      r_proto, n_proto;
    logic [16:0] r_acc, n_acc;
    logic        r_given, n_given;
    logic        r_failed, n_failed;

    // output stage
    logic        r_out_valid;
    logic [7:0]  r_out_ch;
    logic [2:0]  r_out_part;
    logic        r_out_last;
    logic        r_out_ok;
    logic [1:0]  r_out_proto;
    logic [15:0] r_out_port;

    logic        w_s1_ready;
    logic        w_proc;
    logic [7:0]  w_c;
    logic        w_ok;
    logic        w_to_sep;
    logic        w_digit;
    logic [19:0] w_mul;
    t_part       w_part;
    logic        w_valid;
    logic [15:0] w_port;

    assign w_s1_ready    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || w_s1_ready;
    assign w_proc        = r_in_valid && w_s1_ready;

    // ASCII case folding for scheme compare
    assign w_c = (r_in_ch >= CH_UP_A && r_in_ch <= CH_UP_Z) ? r_in_ch + 8'd32 : r_in_ch;

    assign w_digit = (r_in_ch >= CH_ZERO) && (r_in_ch <= CH_NINE);
    // acc*10 + digit; acc <= 65536 so 20 bits hold it
    assign w_mul = ({3'b000, r_acc} << 3) + ({3'b000, r_acc} << 1)
                 + {16'd0, r_in_ch[3:0]};

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_proto  = r_proto;
        n_acc    = r_acc;
        n_given  = r_given;
        n_failed = r_failed;
        w_ok     = 1'b1;
        w_to_sep = 1'b0;
        if (!r_failed) begin
            unique case (r_phase) inside
                PH_SCHEME: begin
                    if (r_pos == 3'd0) begin
                        if (w_c == CH_LO_H) begin
                            n_proto = PROTO_HTTP;
                        end else if (w_c == CH_LO_F) begin
                            n_proto = PROTO_FTP;
                        end else begin
                            w_ok = 1'b0;
                        end
                    end else if (r_proto == PROTO_FTP) begin
                        if ((r_pos == 3'd1 && w_c == CH_LO_T) ||
                            (r_pos == 3'd2 && w_c == CH_LO_P)) begin
                            w_ok = 1'b1;
                        end else if (r_pos == 3'd3 && w_c == CH_COLON) begin
                            w_to_sep = 1'b1;
                        end else begin
                            w_ok = 1'b0;
                        end
                    end else begin
                        if (((r_pos == 3'd1 || r_pos == 3'd2) && w_c == CH_LO_T) ||
                            (r_pos == 3'd3 && w_c == CH_LO_P)) begin
                            w_ok = 1'b1;
                        end else if (r_pos == 3'd4 && w_c == CH_LO_S &&
                                     r_proto == PROTO_HTTP) begin
                            n_proto = PROTO_HTTPS;
                        end else if ((r_pos == 3'd4 ||
                                      (r_pos == 3'd5 && r_proto == PROTO_HTTPS)) &&
                                     w_c == CH_COLON) begin
                            w_to_sep = 1'b1;
                        end else begin
                            w_ok = 1'b0;
                        end
                    end
                    if (w_to_sep) begin
                        n_phase = PH_SEP;
                        n_pos   = 3'd0;
                    end else if (w_ok) begin
                        n_pos = r_pos + 3'd1;
                    end
                end
                PH_SEP: begin
                    if (r_in_ch == CH_SLASH) begin
                        if (r_pos != 3'd0) begin
                            n_phase = PH_HOST_FIRST;
                            n_pos   = 3'd0;
                        end else begin
                            n_pos = r_pos + 3'd1;
                        end
                    end else begin
                        w_ok = 1'b0;
                    end
                end
                PH_HOST_FIRST: begin
                    if (r_in_ch == CH_COLON || r_in_ch == CH_SLASH) begin
                        w_ok = 1'b0;
                    end else begin
                        n_phase = PH_HOST;
                    end
                end
                PH_HOST: begin
                    if (r_in_ch == CH_COLON) begin
                        n_phase = PH_PORT_FIRST;
                        n_given = 1'b1;
                    end else if (r_in_ch == CH_SLASH) begin
                        n_phase = PH_DOC;
                    end
                end
                PH_PORT_FIRST, PH_PORT: begin
                    if (w_digit) begin
                        n_acc   = (w_mul > {3'b000, PORT_SAT}) ? PORT_SAT : w_mul[16:0];
                        n_phase = PH_PORT;
                    end else if (r_in_ch == CH_SLASH && r_phase == PH_PORT) begin
                        n_phase = PH_DOC;
                    end else begin
                        w_ok = 1'b0;
                    end
                end
                default: begin
                    if (r_in_ch == CH_CR || r_in_ch == CH_LF) begin
                        w_ok = 1'b0;
                    end
                end
            endcase
            if (!w_ok) begin
                n_failed = 1'b1;
            end
        end
    end

    // part tag
    always_comb begin
        unique case (r_phase) inside
            PH_SCHEME: begin
                w_part = (!r_failed && w_c == CH_COLON && w_ok) ? PART_SEP : PART_SCHEME;
            end
            PH_SEP: begin
                w_part = PART_SEP;
            end
            PH_HOST_FIRST: begin
                w_part = PART_HOST;
            end
            PH_HOST: begin
                if (!r_failed && r_in_ch == CH_COLON) begin
                    w_part = PART_PORT;
                end else if (!r_failed && r_in_ch == CH_SLASH) begin
                    w_part = PART_SLASH;
                end else begin
                    w_part = PART_HOST;
                end
            end
            PH_PORT_FIRST, PH_PORT: begin
                if (!r_failed && !w_digit && r_in_ch == CH_SLASH && r_phase == PH_PORT) begin
                    w_part = PART_SLASH;
                end else begin
                    w_part = PART_PORT;
                end
            end
            default: begin
                w_part = PART_DOC;
            end
        endcase
    end

    // end-of-URL verdict, from the updated state
    always_comb begin
        w_valid = !n_failed &&
                  (n_phase == PH_HOST || n_phase == PH_PORT || n_phase == PH_DOC);
        if (n_given) begin
            w_port = n_acc[15:0];
            if (n_acc == 17'd0 || n_acc > PORT_MAX) begin
                w_valid = 1'b0;
            end
        end else if (n_proto == PROTO_HTTPS) begin
            w_port = PORT_HTTPS;
        end else if (n_proto == PROTO_FTP) begin
            w_port = PORT_FTP;
        end else begin
            w_port = PORT_HTTP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready) begin
            r_in_ch   <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SCHEME;
            r_pos    <= 3'd0;
            r_proto  <= PROTO_HTTP;
            r_acc    <= 17'd0;
            r_given  <= 1'b0;
            r_failed <= 1'b0;
        end else if (w_proc) begin
            if (r_in_last) begin
                r_phase  <= PH_SCHEME;
                r_pos    <= 3'd0;
                r_proto  <= PROTO_HTTP;
                r_acc    <= 17'd0;
                r_given  <= 1'b0;
                r_failed <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_proto  <= n_proto;
                r_acc    <= n_acc;
                r_given  <= n_given;
                r_failed <= n_failed;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_out_valid <= r_in_valid;
        end
        if (w_proc) begin
            r_out_ch    <= r_in_ch;
            r_out_part  <= w_part;
            r_out_last  <= r_in_last;
            r_out_ok    <= r_in_last && w_valid;
            r_out_proto <= (r_in_last && w_valid) ? n_proto : PROTO_HTTP;
            r_out_port  <= (r_in_last && w_valid) ? w_port : 16'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_port, r_out_proto, r_out_ok, r_out_ch};
    assign m_axis_tuser  = r_out_part;
    assign m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // a final byte leaves the parser at scheme start
    a_reset_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_in_last) |=> (r_phase == PH_SCHEME && !r_failed &&
                                   r_acc == 17'd0 && !r_given))
        else $error("parse state not cleared after last byte");

    a_acc_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= PORT_SAT)
        else $error("port accumulator above saturation value");

    a_verdict_only_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (!r_out_ok && r_out_port == 16'd0))
        else $error("verdict fields set on a non-final byte");

    // once broken, the phase holds until the URL ends
    a_failed_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && r_failed && !r_in_last) |=> (r_failed && $stable(r_phase)))
        else $error("phase moved after pattern failure");
`endif

endmodule
`default_nettype wire
